FILE: rtl/bpq_pkg.sv
// Shared types and constants of the bounded priority ready queue.
// No dependencies; every other file of the block but bpq_chan_if imports this package.
package bpq_pkg;

  localparam int ID_W      = 16;
  localparam int PRI_W     = 8;
  localparam int ENTRY_W   = ID_W + PRI_W;
  localparam int COUNT_O_W = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [ID_W-1:0]  entry_id;
    logic [PRI_W-1:0] entry_priority;
  } req_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 out_valid;
    logic [ID_W-1:0]      out_id;
    logic [PRI_W-1:0]     out_priority;
    logic [COUNT_O_W-1:0] entry_count;
    logic                 is_empty;
  } rsp_item_t;

  typedef struct packed {
    logic fifo_mode;
  } cfg_item_t;

  typedef struct packed {
    logic in_ready;
    logic issue;
    logic fix;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic accept;
    logic do_scan;
    logic scan_last;
    logic fifo;
    logic slot_free;
  } ctl_stat_t;

endpackage

FILE: rtl/bpq_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Used for the request, response and configuration channels.
interface bpq_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bpq_ctrl.sv
// Sequencer of the queue: accept, scan, drain, fix-up and result load.
// Depends on bpq_pkg; drives the command struct of bpq_datapath.
module bpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  bpq_pkg::ctl_stat_t stat,
  output bpq_pkg::ctl_cmd_t  cmd
);
  import bpq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIX   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.accept) begin
          state_next = stat.do_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = stat.fifo ? S_DONE : S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bpq_datapath.sv
// Entry store, scan registers, occupancy, mode register and result register.
// Depends on bpq_pkg and bpq_chan_if; sequenced by bpq_ctrl.
module bpq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bpq_pkg::ctl_cmd_t cmd,
  output bpq_pkg::ctl_stat_t stat,
  bpq_chan_if.sink          req,
  bpq_chan_if.source        rsp,
  bpq_chan_if.sink          cfg
);
  import bpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] mem [DEPTH];

  logic [CW-1:0]      count;
  logic               fifo_mode;
  logic [AW-1:0]      scan_idx;
  logic [AW-1:0]      rd_idx;
  logic               rd_valid;
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      best_idx;
  logic [ENTRY_W-1:0] best;
  logic [ENTRY_W-1:0] last_entry;
  logic [1:0]         status_q;
  logic               deq_ok;
  rsp_item_t          res;
  logic               res_valid;

  logic               accept;
  logic               full;
  logic               enq_ok;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [CW-1:0]      count_after;

  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign enq_ok    = accept && (req.data.cmd == CMD_ENQ) && !full;

  assign stat.accept    = accept;
  assign stat.do_scan   = (req.data.cmd == CMD_DEQ) && (count != '0);
  assign stat.scan_last = (CW'(scan_idx) == count - CW'(1));
  assign stat.fifo      = fifo_mode;
  assign stat.slot_free = !res_valid || rsp.ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = last_entry;
    priority if (enq_ok) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = {req.data.entry_id, req.data.entry_priority};
    end else if (rd_valid && fifo_mode && (rd_idx != '0)) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
      wr_data = rdata;
    end else if (cmd.fix) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = last_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rdata <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_mode <= 1'b0;
    end else if (cfg.valid) begin
      fifo_mode <= cfg.data.fifo_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  // scan bookkeeping and per-item outcome
  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (accept) begin
      scan_idx <= '0;
      deq_ok   <= (req.data.cmd == CMD_DEQ) && (count != '0);
      priority if (req.data.cmd == CMD_ENQ) begin
        status_q <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        status_q <= (count == '0) ? STATUS_EMPTY : STATUS_OK;
      end
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + AW'(1);
    end
    if (rd_valid) begin
      last_entry <= rdata;
      if (rd_idx == '0 ||
          (!fifo_mode && (rdata[PRI_W-1:0] > best[PRI_W-1:0]))) begin
        best     <= rdata;
        best_idx <= rd_idx;
      end
    end
  end

  assign count_after = deq_ok ? count - CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (enq_ok) begin
      count <= count + CW'(1);
    end else if (cmd.load && deq_ok) begin
      count <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.status       <= status_q;
      res.out_valid    <= deq_ok;
      res.out_id       <= deq_ok ? best[ENTRY_W-1:PRI_W] : '0;
      res.out_priority <= deq_ok ? best[PRI_W-1:0] : '0;
      res.entry_count  <= COUNT_O_W'(count_after);
      res.is_empty     <= (count_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.data  = res;

endmodule

FILE: rtl/bounded_priority_ready_queue.sv
// Top level of the bounded priority ready queue: sequencer plus datapath.
// Depends on bpq_pkg, bpq_chan_if, bpq_ctrl and bpq_datapath.
//
// Holds up to DEPTH entries (16-bit id, 8-bit priority) in a RAM with one
// read and one write port; each request item gives one response item. An
// enqueue, or a dequeue on an empty queue, goes through the result load
// back to idle for the next accept. A dequeue of n held entries reads the
// RAM once per entry: in FIFO mode the head goes out and the rest shift
// down; in priority mode the first highest priority goes out and the last
// entry is moved into its slot. The response sits in an output register,
// so a new request is taken while the previous response waits. fifo_mode
// must be written by the user through cfg while idle; not enforced.
module bounded_priority_ready_queue #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  bpq_chan_if.sink   req,
  bpq_chan_if.source rsp,
  bpq_chan_if.sink   cfg
);
  import bpq_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  bpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  bpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg)
  );

endmodule

FILE: rtl/bpq_checker.sv
// Port-level checks of the bounded priority ready queue, bound to the top.
// Depends on bpq_pkg and bounded_priority_ready_queue.
module bpq_checker #(
  parameter int DEPTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input bpq_pkg::rsp_item_t    rsp_data
);
  import bpq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.out_valid |-> rsp_data.out_id == '0 &&
      rsp_data.out_priority == '0)
    else $error("nonzero entry without a removed item");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == STATUS_FULL |->
      rsp_data.entry_count == COUNT_O_W'(DEPTH) && !rsp_data.out_valid)
    else $error("full status with wrong count");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == STATUS_EMPTY |->
      rsp_data.is_empty && rsp_data.entry_count == '0 && !rsp_data.out_valid)
    else $error("empty status on a nonempty queue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind bounded_priority_ready_queue bpq_checker #(
  .DEPTH (DEPTH)
) u_bpq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
